@@ rtl/core/tdm_pkg.sv @@
// ----------------------------------------------------------------------------
// tdm_pkg: shared types and constants of the tank drive mixer
// Register indexes, mode bits and fixed-point widths of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE     = 3'd0,
        CFG_GAIN     = 3'd1,
        CFG_DEADZONE = 3'd2,
        CFG_EXPO     = 3'd3,
        CFG_ARCADE   = 3'd4,
        CFG_SPEED    = 3'd5
    } t_cfg_idx;

    // mode_flags bits
    localparam int MODE_FAST   = 0;
    localparam int MODE_INV_A  = 1;
    localparam int MODE_INV_B  = 2;
    localparam int MODE_INV_Y  = 3;
    localparam int MODE_INV_X  = 4;
    localparam int MODE_ARCADE = 5;

    // fixed-point widths
    localparam int QUO_W      = 15;  // normalized magnitude, Q1.14
    localparam int SHAPE_W    = 17;  // shaped magnitude, Q3.14
    localparam int SIDE_W     = 18;  // mixed side magnitude
    localparam int AX_NUM_W   = 39;
    localparam int AX_DEN_W   = 17;
    localparam int MIX_NUM_W  = 34;
    localparam int MIX_DEN_W  = 19;

endpackage

`default_nettype wire

@@ rtl/core/tdm_div.sv @@
// ----------------------------------------------------------------------------
// tdm_div: pipelined restoring divider
// One quotient bit per stage; quotient saturates to all ones on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_div #(
    parameter int NUM_W  = 39,
    parameter int DEN_W  = 17,
    parameter int QUO_W  = 15,
    parameter int SIDE_W = 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  wire [NUM_W-1:0]   i_num,
    input  wire [DEN_W-1:0]   i_den,
    input  wire [SIDE_W-1:0]  i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CMP_W-1:0] num_x;
    logic [CMP_W-1:0] lim_x;
    logic             n_sat;
    logic [DEN_W-1:0] n_rem0;

    logic [DEN_W-1:0]  r_rem  [0:QUO_W-1];
    logic [DEN_W-1:0]  r_den  [0:QUO_W-1];
    logic [QUO_W-1:0]  r_low  [0:QUO_W-1];
    logic [QUO_W-1:0]  r_quo  [0:QUO_W];
    logic              r_sat  [0:QUO_W];
    logic [SIDE_W-1:0] r_side [0:QUO_W];
    logic              r_valid[0:QUO_W];

    always_comb begin
        num_x  = CMP_W'(i_num);
        lim_x  = CMP_W'(i_den) << QUO_W;
        n_sat  = (num_x >= lim_x);
        n_rem0 = num_x[QUO_W +: DEN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem0;
            r_den[0]  <= i_den;
            r_low[0]  <= i_num[QUO_W-1:0];
            r_quo[0]  <= '0;
            r_sat[0]  <= n_sat;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        logic [DEN_W:0] cand;
        logic [DEN_W:0] diff;
        logic           ge;

        // shift in the next dividend bit, subtract when it fits
        assign cand = {r_rem[s-1], r_low[s-1][QUO_W-1]};
        assign ge   = (cand >= {1'b0, r_den[s-1]});
        assign diff = cand - {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= r_valid[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s]  <= QUO_W'({r_quo[s-1], ge});
                r_sat[s]  <= r_sat[s-1];
                r_side[s] <= r_side[s-1];
            end
        end

        if (s < QUO_W) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
                    r_den[s] <= r_den[s-1];
                    r_low[s] <= r_low[s-1] << 1;
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo   = r_sat[QUO_W] ? '1 : r_quo[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

`default_nettype wire

@@ rtl/core/tank_drive_mixer_hbridge_pwm.sv @@
// ----------------------------------------------------------------------------
// tank_drive_mixer_hbridge_pwm: differential drive mixer for two H-bridges
//
// Input channel: i_valid / o_stall carry one throttle, steer and full-scale
// beat; a beat is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry the four bridge pin duties and the
// two target duties of one beat; taken with o_valid high and i_stall low.
// Configuration: i_cfg_valid / o_cfg_ready write register i_cfg_index with
// i_cfg_data; o_cfg_ready is always high. Write only while the pipe is empty.
//
// Throughput: one beat per cycle unless the output beat is held. The pipe is
// built from three input stages, the two 16-stage dividers (axis normalization
// and side rescale), the four-stage expo, three-stage arcade, two mix stages,
// two duty stages and the output register.
// The whole pipe advances as one; it holds when the output register holds a
// beat and the receiver stalls, so o_stall follows i_stall in that case.
// Reset (synchronous, active low) empties the pipe and loads register
// defaults: unity steer gain, full speed limit, everything else zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_drive_mixer_hbridge_pwm
    import tdm_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_throttle,
    input  wire  [15:0] i_steer,
    input  wire  [15:0] i_full_scale,
    // result channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [9:0]  o_left_pin1_duty,
    output logic [9:0]  o_left_pin2_duty,
    output logic [9:0]  o_right_pin1_duty,
    output logic [9:0]  o_right_pin2_duty,
    output logic [9:0]  o_left_target,
    output logic [9:0]  o_right_target,
    // configuration write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int AX_X = 0;  // steer axis
    localparam int AX_Y = 1;  // throttle axis
    localparam int MD_L = 0;  // left side
    localparam int MD_R = 1;  // right side
    localparam int PROD_W = 31 + DUTY_BITS;
    localparam logic [DUTY_BITS-1:0] MAXD = '1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [5:0]  r_mode;
    logic [15:0] r_gain;
    logic [15:0] r_dz;
    logic [15:0] r_expo;
    logic [15:0] r_arcade;
    logic [15:0] r_speed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_gain   <= 16'd256;
            r_dz     <= '0;
            r_expo   <= '0;
            r_arcade <= '0;
            r_speed  <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode   <= i_cfg_data[5:0];
                CFG_GAIN:     r_gain   <= i_cfg_data;
                CFG_DEADZONE: r_dz     <= i_cfg_data;
                CFG_EXPO:     r_expo   <= i_cfg_data;
                CFG_ARCADE:   r_arcade <= i_cfg_data;
                CFG_SPEED:    r_speed  <= i_cfg_data;
                default: ;    // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe advance: move everything unless the output beat is held
    // ------------------------------------------------------------------
    logic en;
    logic r_vo;

    assign en      = !r_vo || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vo;

    // ------------------------------------------------------------------
    // S1: capture the command beat
    // ------------------------------------------------------------------
    logic        r_v1;
    logic [15:0] r_s1_y;
    logic [15:0] r_s1_x;
    logic [15:0] r_s1_fs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_y  <= i_throttle;
            r_s1_x  <= i_steer;
            r_s1_fs <= i_full_scale;
        end
    end

    // ------------------------------------------------------------------
    // S2: optional inversion, sign and magnitude, zero full scale as one
    // ------------------------------------------------------------------
    logic        r_v2;
    logic [16:0] r_s2_xmag;
    logic [16:0] r_s2_ymag;
    logic        r_s2_xneg;
    logic        r_s2_yneg;
    logic [15:0] r_s2_fs;

    logic signed [16:0] s2_xs;
    logic signed [16:0] s2_ys;

    always_comb begin
        s2_xs = 17'(signed'(r_s1_x));
        s2_ys = 17'(signed'(r_s1_y));
        if (r_mode[MODE_INV_X]) begin
            s2_xs = -s2_xs;
        end
        if (r_mode[MODE_INV_Y]) begin
            s2_ys = -s2_ys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_xneg <= s2_xs[16];
            r_s2_yneg <= s2_ys[16];
            r_s2_xmag <= s2_xs[16] ? 17'(-s2_xs) : 17'(s2_xs);
            r_s2_ymag <= s2_ys[16] ? 17'(-s2_ys) : 17'(s2_ys);
            r_s2_fs   <= (r_s1_fs == 16'd0) ? 16'd1 : r_s1_fs;
        end
    end

    // ------------------------------------------------------------------
    // S3: steer gain, build dividends for round(v * 2^14 / fs)
    // ------------------------------------------------------------------
    logic                r_v3;
    logic [AX_NUM_W-1:0] r_s3_nx;
    logic [AX_NUM_W-1:0] r_s3_ny;
    logic [AX_DEN_W-1:0] r_s3_den;
    logic                r_s3_xneg;
    logic                r_s3_yneg;

    logic [30:0] s3_xprod;

    assign s3_xprod = 31'(r_s2_xmag * r_gain);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_nx   <= AX_NUM_W'({s3_xprod, 7'd0}) + AX_NUM_W'(r_s2_fs);
            r_s3_ny   <= AX_NUM_W'({r_s2_ymag, 15'd0}) + AX_NUM_W'(r_s2_fs);
            r_s3_den  <= {r_s2_fs, 1'b0};
            r_s3_xneg <= r_s2_xneg;
            r_s3_yneg <= r_s2_yneg;
        end
    end

    // ------------------------------------------------------------------
    // axis normalization dividers, saturate to 32767
    // ------------------------------------------------------------------
    logic             dx_valid;
    logic             dy_valid;
    logic [QUO_W-1:0] div_q [0:1];
    logic             div_neg [0:1];

    tdm_div #(
        .NUM_W (AX_NUM_W),
        .DEN_W (AX_DEN_W),
        .QUO_W (QUO_W),
        .SIDE_W(1)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_v3),
        .i_num  (r_s3_nx),
        .i_den  (r_s3_den),
        .i_side (r_s3_xneg),
        .o_valid(dx_valid),
        .o_quo  (div_q[AX_X]),
        .o_side (div_neg[AX_X])
    );

    tdm_div #(
        .NUM_W (AX_NUM_W),
        .DEN_W (AX_DEN_W),
        .QUO_W (QUO_W),
        .SIDE_W(1)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_v3),
        .i_num  (r_s3_ny),
        .i_den  (r_s3_den),
        .i_side (r_s3_yneg),
        .o_valid(dy_valid),
        .o_quo  (div_q[AX_Y]),
        .o_side (div_neg[AX_Y])
    );

    // ------------------------------------------------------------------
    // E1..E4: deadzone and expo (1-e)q + e q^3, per axis
    // ------------------------------------------------------------------
    logic             r_ve1, r_ve2, r_ve3, r_ve4;
    logic [QUO_W-1:0] r_e1_q   [0:1];
    logic [29:0]      r_e1_qq  [0:1];
    logic             r_e1_dz  [0:1];
    logic             r_e1_neg [0:1];
    logic [44:0]      r_e2_q3  [0:1];
    logic [31:0]      r_e2_t1  [0:1];
    logic             r_e2_dz  [0:1];
    logic             r_e2_neg [0:1];
    logic [60:0]      r_e3_t2  [0:1];
    logic [31:0]      r_e3_t1  [0:1];
    logic             r_e3_dz  [0:1];
    logic             r_e3_neg [0:1];
    logic [SHAPE_W-1:0] r_e4_m   [0:1];
    logic               r_e4_neg [0:1];

    logic [16:0]        e_inv;
    logic [63:0]        e4_sum [0:1];
    logic [SHAPE_W-1:0] e4_m   [0:1];

    assign e_inv = 17'h10000 - {1'b0, r_expo};

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            e4_sum[a] = {4'd0, r_e3_t1[a], 28'd0} + {3'd0, r_e3_t2[a]}
                      + 64'h0000_0800_0000_0000;
            if (r_e3_dz[a]) begin
                e4_m[a] = '0;
            end else if (e4_sum[a][63:44] > 20'd131071) begin
                e4_m[a] = '1;
            end else begin
                e4_m[a] = e4_sum[a][44 +: SHAPE_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                r_e1_q[a]   <= div_q[a];
                r_e1_qq[a]  <= 30'(div_q[a] * div_q[a]);
                r_e1_dz[a]  <= ({div_q[a], 2'b00} <= {1'b0, r_dz});
                r_e1_neg[a] <= div_neg[a];

                r_e2_q3[a]  <= 45'(r_e1_qq[a] * r_e1_q[a]);
                r_e2_t1[a]  <= 32'(e_inv * r_e1_q[a]);
                r_e2_dz[a]  <= r_e1_dz[a];
                r_e2_neg[a] <= r_e1_neg[a];

                r_e3_t2[a]  <= 61'(r_expo * r_e2_q3[a]);
                r_e3_t1[a]  <= r_e2_t1[a];
                r_e3_dz[a]  <= r_e2_dz[a];
                r_e3_neg[a] <= r_e2_neg[a];

                r_e4_m[a]   <= e4_m[a];
                r_e4_neg[a] <= r_e3_neg[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // A1..A3: arcade steer reduction x * (1 - min(y,1) * arcade)
    // ------------------------------------------------------------------
    logic               r_va1, r_va2, r_va3;
    logic [30:0]        r_a1_p;
    logic [SHAPE_W-1:0] r_a1_m   [0:1];
    logic               r_a1_neg [0:1];
    logic [47:0]        r_a2_xf;
    logic [SHAPE_W-1:0] r_a2_m   [0:1];
    logic               r_a2_neg [0:1];
    logic [SHAPE_W-1:0] r_a3_m   [0:1];
    logic               r_a3_neg [0:1];

    logic [14:0] a1_yc;
    logic [30:0] a2_f;
    logic [48:0] a3_rnd;

    assign a1_yc  = (r_e4_m[AX_Y] >= 17'd16384) ? 15'd16384 : r_e4_m[AX_Y][14:0];
    assign a2_f   = 31'h4000_0000 - r_a1_p;
    assign a3_rnd = {1'b0, r_a2_xf} + 49'h0_2000_0000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1_p <= 31'(a1_yc * r_arcade);
            r_a2_xf <= 48'(r_a1_m[AX_X] * a2_f);
            for (int a = 0; a < 2; a++) begin
                r_a1_m[a]   <= r_e4_m[a];
                r_a1_neg[a] <= r_e4_neg[a];
                r_a2_m[a]   <= r_a1_m[a];
                r_a2_neg[a] <= r_a1_neg[a];
                r_a3_neg[a] <= r_a2_neg[a];
            end
            r_a3_m[AX_Y] <= r_a2_m[AX_Y];
            r_a3_m[AX_X] <= r_mode[MODE_ARCADE] ? a3_rnd[30 +: SHAPE_W] : r_a2_m[AX_X];
        end
    end

    // ------------------------------------------------------------------
    // M1..M2: left = y + x, right = y - x, prepare rescale by the larger
    // ------------------------------------------------------------------
    logic                r_vm1, r_vm2;
    logic [SIDE_W-1:0]   r_m1_mag [0:1];
    logic                r_m1_neg [0:1];
    logic [MIX_NUM_W-1:0] r_m2_num [0:1];
    logic [MIX_DEN_W-1:0] r_m2_den;
    logic [SIDE_W+1:0]   r_m2_side [0:1];  // {rescale, reverse, magnitude}

    logic signed [18:0] m1_sx;
    logic signed [18:0] m1_sy;
    logic signed [18:0] m1_v [0:1];
    logic [SIDE_W-1:0]  m2_mx;
    logic               m2_big;

    always_comb begin
        m1_sx = $signed({2'b00, r_a3_m[AX_X]});
        m1_sy = $signed({2'b00, r_a3_m[AX_Y]});
        if (r_a3_neg[AX_X]) begin
            m1_sx = -m1_sx;
        end
        if (r_a3_neg[AX_Y]) begin
            m1_sy = -m1_sy;
        end
        m1_v[MD_L] = m1_sy + m1_sx;
        m1_v[MD_R] = m1_sy - m1_sx;
    end

    assign m2_mx  = (r_m1_mag[MD_L] > r_m1_mag[MD_R]) ? r_m1_mag[MD_L] : r_m1_mag[MD_R];
    assign m2_big = (m2_mx > 18'd16384);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 2; m++) begin
                r_m1_neg[m] <= m1_v[m][18];
                r_m1_mag[m] <= m1_v[m][18] ? 18'(-m1_v[m]) : m1_v[m][17:0];
                r_m2_num[m] <= MIX_NUM_W'({r_m1_mag[m], 15'd0}) + MIX_NUM_W'(m2_mx);
                r_m2_side[m] <= {m2_big, r_m1_neg[m], r_m1_mag[m]};
            end
            r_m2_den <= {m2_mx, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // side rescale dividers: round(mag * 2^14 / max)
    // ------------------------------------------------------------------
    logic              dl_valid;
    logic              dr_valid;
    logic [QUO_W-1:0]  mix_q    [0:1];
    logic [SIDE_W+1:0] mix_side [0:1];

    tdm_div #(
        .NUM_W (MIX_NUM_W),
        .DEN_W (MIX_DEN_W),
        .QUO_W (QUO_W),
        .SIDE_W(SIDE_W + 2)
    ) u_div_l (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_vm2),
        .i_num  (r_m2_num[MD_L]),
        .i_den  (r_m2_den),
        .i_side (r_m2_side[MD_L]),
        .o_valid(dl_valid),
        .o_quo  (mix_q[MD_L]),
        .o_side (mix_side[MD_L])
    );

    tdm_div #(
        .NUM_W (MIX_NUM_W),
        .DEN_W (MIX_DEN_W),
        .QUO_W (QUO_W),
        .SIDE_W(SIDE_W + 2)
    ) u_div_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_vm2),
        .i_num  (r_m2_num[MD_R]),
        .i_den  (r_m2_den),
        .i_side (r_m2_side[MD_R]),
        .o_valid(dr_valid),
        .o_quo  (mix_q[MD_R]),
        .o_side (mix_side[MD_R])
    );

    // ------------------------------------------------------------------
    // D1..D3: duty = round(mag * speed * MAXD / 2^30), then bridge pins
    // ------------------------------------------------------------------
    logic              r_vd1, r_vd2;
    logic [30:0]       r_d1_p   [0:1];
    logic              r_d1_neg [0:1];
    logic [PROD_W-1:0] r_d2_t   [0:1];
    logic              r_d2_neg [0:1];

    logic [QUO_W-1:0]     d1_mag [0:1];
    logic [PROD_W:0]      d3_rnd [0:1];
    logic [DUTY_BITS-1:0] d3_duty [0:1];
    logic                 d3_fwd  [0:1];
    logic [DUTY_BITS-1:0] d3_p1   [0:1];
    logic [DUTY_BITS-1:0] d3_p2   [0:1];

    function automatic logic [9:0] to_out(input logic [DUTY_BITS-1:0] v);
        logic [DUTY_BITS+9:0] w;
        w = {10'd0, v};
        return w[9:0];
    endfunction

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            // keep the mixed magnitude when no side exceeds one
            d1_mag[m] = mix_side[m][SIDE_W+1] ? mix_q[m] : mix_side[m][QUO_W-1:0];
            d3_rnd[m] = (PROD_W+1)'(r_d2_t[m]) + (PROD_W+1)'(32'h2000_0000);
            d3_duty[m] = d3_rnd[m][30 +: DUTY_BITS];
        end
        d3_fwd[MD_L] = !r_d2_neg[MD_L] ^ r_mode[MODE_INV_A];
        d3_fwd[MD_R] = !r_d2_neg[MD_R] ^ r_mode[MODE_INV_B];
        for (int m = 0; m < 2; m++) begin
            if (r_mode[MODE_FAST]) begin
                // fast decay: drive one pin, coast the other
                d3_p1[m] = d3_fwd[m] ? d3_duty[m] : '0;
                d3_p2[m] = d3_fwd[m] ? '0 : d3_duty[m];
            end else begin
                // slow decay: inverted duty against a pin held high
                d3_p1[m] = d3_fwd[m] ? MAXD - d3_duty[m] : MAXD;
                d3_p2[m] = d3_fwd[m] ? MAXD : MAXD - d3_duty[m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 2; m++) begin
                r_d1_p[m]   <= 31'(d1_mag[m] * r_speed);
                r_d1_neg[m] <= mix_side[m][SIDE_W];
                r_d2_t[m]   <= PROD_W'(r_d1_p[m] * MAXD);
                r_d2_neg[m] <= r_d1_neg[m];
            end
            o_left_pin1_duty  <= to_out(d3_p1[MD_L]);
            o_left_pin2_duty  <= to_out(d3_p2[MD_L]);
            o_right_pin1_duty <= to_out(d3_p1[MD_R]);
            o_right_pin2_duty <= to_out(d3_p2[MD_R]);
            o_left_target     <= to_out(d3_duty[MD_L]);
            o_right_target    <= to_out(d3_duty[MD_R]);
        end
    end

    // ------------------------------------------------------------------
    // valid bits, cleared by reset, advance with the data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_ve1 <= 1'b0;
            r_ve2 <= 1'b0;
            r_ve3 <= 1'b0;
            r_ve4 <= 1'b0;
            r_va1 <= 1'b0;
            r_va2 <= 1'b0;
            r_va3 <= 1'b0;
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_vd1 <= 1'b0;
            r_vd2 <= 1'b0;
            r_vo  <= 1'b0;
        end else if (en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_ve1 <= dx_valid & dy_valid;
            r_ve2 <= r_ve1;
            r_ve3 <= r_ve2;
            r_ve4 <= r_ve3;
            r_va1 <= r_ve4;
            r_va2 <= r_va1;
            r_va3 <= r_va2;
            r_vm1 <= r_va3;
            r_vm2 <= r_vm1;
            r_vd1 <= dl_valid & dr_valid;
            r_vd2 <= r_vd1;
            r_vo  <= r_vd2;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tdm_chk.sv @@
// ----------------------------------------------------------------------------
// tdm_chk: port-level checks of the tank drive mixer
// Reset, output hold, stall behavior and bridge pin pairing.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_chk #(
    parameter int DUTY_BITS = 10
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [9:0]  o_left_pin1_duty,
    input wire [9:0]  o_left_pin2_duty,
    input wire [9:0]  o_right_pin1_duty,
    input wire [9:0]  o_right_pin2_duty,
    input wire [9:0]  o_left_target,
    input wire [9:0]  o_right_target
);

    localparam logic [DUTY_BITS+9:0] MAXD_W = {10'd0, {DUTY_BITS{1'b1}}};
    localparam logic [9:0] MAXD10 = MAXD_W[9:0];

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // held beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_target)
            && $stable(o_right_target) && $stable(o_left_pin1_duty))
        else $error("stalled result changed");

    // no stall back to the sender while the output register is free
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall with empty output register");

    // one pin of each bridge is coasting or held fully on
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_pin1_duty == 10'd0 || o_left_pin2_duty == 10'd0
            || o_left_pin1_duty == MAXD10 || o_left_pin2_duty == MAXD10)
            && (o_right_pin1_duty == 10'd0 || o_right_pin2_duty == 10'd0
            || o_right_pin1_duty == MAXD10 || o_right_pin2_duty == MAXD10))
        else $error("bridge pin pair out of pattern");

endmodule

bind tank_drive_mixer_hbridge_pwm tdm_chk #(
    .DUTY_BITS(DUTY_BITS)
) u_tdm_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_left_pin1_duty (o_left_pin1_duty),
    .o_left_pin2_duty (o_left_pin2_duty),
    .o_right_pin1_duty(o_right_pin1_duty),
    .o_right_pin2_duty(o_right_pin2_duty),
    .o_left_target    (o_left_target),
    .o_right_target   (o_right_target)
);

`default_nettype wire

@@ verif/tank_drive_mixer_hbridge_pwm_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tank_drive_mixer_hbridge_pwm_tb: self-checking bench of the tank drive mixer
// Walks a directed table of commands across several register settings, then
// random commands with random idling on both sides. Every output beat is
// compared field by field against a typed-in row or an in-bench mixer model.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_drive_mixer_hbridge_pwm_tb;
    import tdm_pkg::*;

    localparam int PIPE_LAT   = 47;
    localparam int DOG_LIMIT  = 20000;
    localparam int RAND_ITEMS = 1750;
    localparam logic [63:0] MAXD = 64'd1023;

    typedef struct packed {
        logic [9:0] l1;
        logic [9:0] l2;
        logic [9:0] r1;
        logic [9:0] r2;
        logic [9:0] lt;
        logic [9:0] rt;
    } duty_set_t;

    typedef struct packed {
        logic [15:0] thr;
        logic [15:0] str;
        logic [15:0] fs;
        logic        known;   // expected row typed in
        duty_set_t   want;
    } cmd_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_throttle = '0;
    logic [15:0] i_steer = '0;
    logic [15:0] i_full_scale = 16'd1;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [9:0]  o_left_pin1_duty, o_left_pin2_duty, o_right_pin1_duty;
    logic [9:0]  o_right_pin2_duty, o_left_target, o_right_target;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    tank_drive_mixer_hbridge_pwm dut (.*);

    // bench copy of the registers
    logic [5:0]  mode_r;
    logic [15:0] gain_r, dz_r, expo_r, arc_r, speed_r;

    duty_set_t duty_q[$];
    int errors = 0;
    int mism = 0;
    int beats_in = 0;
    int beats_out = 0;
    int dog = 0;
    int idle_pct = 0;      // sender idle percent
    int stall_pct = 0;     // receiver stall percent
    int hold_cycles = 0;   // forced long receiver hold-off
    bit dog_fired = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // normalize, deadzone and expo one axis magnitude (Q3.14)
    function automatic logic [63:0] shape_mag(logic [63:0] num, logic [63:0] den);
        logic [63:0] q, m;
        q = (num * 32768 + den) / (2 * den);
        if (q > 32767) q = 32767;
        if (q * 4 <= {48'd0, dz_r}) return 0;
        m = (((64'd65536 - expo_r) * q) << 28) + expo_r * q * q * q;
        q = (m + (64'd1 << 43)) >> 44;
        return q > 131071 ? 64'd131071 : q;
    endfunction

    function automatic void bridge_pins(bit fwd, bit inv, logic [63:0] duty,
                                        output logic [9:0] p1, output logic [9:0] p2);
        if (inv) fwd = !fwd;
        if (mode_r[MODE_FAST]) begin
            p1 = fwd ? duty[9:0] : 10'd0;
            p2 = fwd ? 10'd0 : duty[9:0];
        end else begin
            p1 = fwd ? 10'(MAXD - duty) : 10'(MAXD);
            p2 = fwd ? 10'(MAXD) : 10'(MAXD - duty);
        end
    endfunction

    function automatic duty_set_t mix_duties(logic [15:0] thr, logic [15:0] str,
                                             logic [15:0] fs_in);
        longint yi, xi, sx, sy, l, r;
        logic [63:0] den, xm, ym, al, ar, mx, yc, f, tl, tr;
        bit xneg, yneg;
        duty_set_t d;
        yi = longint'($signed(thr));
        xi = longint'($signed(str));
        den = 256 * ((fs_in == 0) ? 64'd1 : 64'(fs_in));
        if (mode_r[MODE_INV_Y]) yi = -yi;
        if (mode_r[MODE_INV_X]) xi = -xi;
        xneg = xi < 0;
        yneg = yi < 0;
        xm = shape_mag(64'(xneg ? -xi : xi) * gain_r, den);
        ym = shape_mag(64'(yneg ? -yi : yi) * 256, den);
        if (mode_r[MODE_ARCADE]) begin
            yc = ym < 16384 ? ym : 64'd16384;
            f = (64'd1 << 30) - yc * arc_r;
            xm = (xm * f + (64'd1 << 29)) >> 30;
        end
        sx = xneg ? -longint'(xm) : longint'(xm);
        sy = yneg ? -longint'(ym) : longint'(ym);
        l = sy + sx;
        r = sy - sx;
        al = 64'(l < 0 ? -l : l);
        ar = 64'(r < 0 ? -r : r);
        mx = al > ar ? al : ar;
        if (mx > 16384) begin
            al = (al * 32768 + mx) / (2 * mx);
            ar = (ar * 32768 + mx) / (2 * mx);
        end
        if (al > 16384) al = 16384;
        if (ar > 16384) ar = 16384;
        tl = (al * speed_r * MAXD + (64'd1 << 29)) >> 30;
        tr = (ar * speed_r * MAXD + (64'd1 << 29)) >> 30;
        bridge_pins(l >= 0, mode_r[MODE_INV_A], tl, d.l1, d.l2);
        bridge_pins(r >= 0, mode_r[MODE_INV_B], tr, d.r1, d.r2);
        d.lt = tl[9:0];
        d.rt = tr[9:0];
        return d;
    endfunction

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        duty_set_t got, exp_d;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) dog <= 0;
            else dog <= dog + 1;
            if (o_valid && !i_stall) begin
                got = '{o_left_pin1_duty, o_left_pin2_duty, o_right_pin1_duty,
                        o_right_pin2_duty, o_left_target, o_right_target};
                beats_out++;
                if (duty_q.size() == 0) begin
                    errors++;
                    $display("ERROR: output beat with nothing expected");
                end else begin
                    exp_d = duty_q.pop_front();
                    if (got !== exp_d) begin
                        errors++;
                        mism++;
                        if (mism <= 10)
                            $display({"MISMATCH beat %0d: exp l %0d/%0d r %0d/%0d ",
                                      "t %0d/%0d, got l %0d/%0d r %0d/%0d t %0d/%0d"},
                                     beats_out, exp_d.l1, exp_d.l2, exp_d.r1, exp_d.r2,
                                     exp_d.lt, exp_d.rt, got.l1, got.l2, got.r1,
                                     got.r2, got.lt, got.rt);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (dog >= DOG_LIMIT && !dog_fired) begin
            dog_fired = 1;
            $display("Watchdog: no beat for %0d cycles", DOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // write one register; hold the bench copy in step
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:     mode_r  = val[5:0];
            CFG_GAIN:     gain_r  = val;
            CFG_DEADZONE: dz_r    = val;
            CFG_EXPO:     expo_r  = val;
            CFG_ARCADE:   arc_r   = val;
            default:      speed_r = val;
        endcase
    endtask

    task automatic write_all(logic [5:0] m, logic [15:0] g, logic [15:0] dz,
                             logic [15:0] e, logic [15:0] a, logic [15:0] s);
        write_reg(CFG_MODE, 16'(m));
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DEADZONE, dz);
        write_reg(CFG_EXPO, e);
        write_reg(CFG_ARCADE, a);
        write_reg(CFG_SPEED, s);
    endtask

    // drain the pipe before touching registers
    task automatic wait_drained();
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // offer one command beat; hold it until accepted
    task automatic send_cmd(logic [15:0] thr, logic [15:0] str, logic [15:0] fs,
                            bit known, duty_set_t want);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_throttle   <= thr;
        i_steer      <= str;
        i_full_scale <= fs;
        do @(posedge i_clk); while (o_stall);
        duty_q.push_back(known ? want : mix_duties(thr, str, fs));
        beats_in++;
    endtask

    function automatic logic [15:0] rand_fs();
        case ($urandom_range(7))
            0: return 16'($urandom_range(1, 8));
            1: return 16'hFFFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(1000, 40000));
        endcase
    endfunction

    cmd_row_t dir_tab[$];

    initial begin
        duty_set_t none;
        int phase;
        none = '0;
        mode_r = 0; gain_r = 256; dz_r = 0; expo_r = 0; arc_r = 0; speed_r = 16'hFFFF;

        // known rows at reset defaults (slow decay, full speed)
        dir_tab.push_back('{16'd0, 16'd0, 16'd1, 1, '{10'd1023, 10'd1023, 10'd1023,
                                                     10'd1023, 10'd0, 10'd0}});
        dir_tab.push_back('{16'h7FFF, 16'd0, 16'h7FFF, 1, '{10'd0, 10'd1023, 10'd0,
                                                           10'd1023, 10'd1023, 10'd1023}});
        dir_tab.push_back('{16'h8000, 16'd0, 16'h8000, 1, '{10'd1023, 10'd0, 10'd1023,
                                                           10'd0, 10'd1023, 10'd1023}});
        dir_tab.push_back('{16'h7FFF, 16'h7FFF, 16'h0000, 0, none});
        dir_tab.push_back('{16'h8000, 16'h8000, 16'hFFFF, 0, none});
        dir_tab.push_back('{16'd0, 16'h7FFF, 16'd1, 0, none});
        dir_tab.push_back('{16'd1, 16'hFFFF, 16'd1, 0, none});
        dir_tab.push_back('{16'd100, 16'd50, 16'd200, 0, none});
        dir_tab.push_back('{16'hFF00, 16'h0123, 16'd512, 0, none});
        dir_tab.push_back('{16'h5555, 16'hAAAA, 16'hFFFF, 0, none});
        dir_tab.push_back('{16'hAAAA, 16'h5555, 16'h8001, 0, none});
        dir_tab.push_back('{16'd300, 16'hFED4, 16'd1000, 0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under several settings, extremes among them
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                1: write_all(6'h3F, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_all(6'h01, 16'd0, 16'hFFFF, 16'h8000, 16'd0, 16'd0);
                3: write_all(6'h26, 16'h0180, 16'h0800, 16'h4000, 16'h8000, 16'hC000);
                default: ;
            endcase
            foreach (dir_tab[k])
                send_cmd(dir_tab[k].thr, dir_tab[k].str, dir_tab[k].fs,
                         phase == 0 && dir_tab[k].known, dir_tab[k].want);
            i_valid <= 1'b0;
            wait_drained();
        end

        // random part: settings per phase, idling phases rotate
        for (phase = 0; phase < 8; phase++) begin
            write_all(6'($urandom_range(63)), 16'($urandom_range(65535) >> $urandom_range(7)),
                      16'($urandom_range(65535) >> $urandom_range(4, 15)),
                      16'($urandom), 16'($urandom), 16'($urandom));
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            if (phase == 2) hold_cycles = 3 * PIPE_LAT;  // fill the pipe
            repeat (RAND_ITEMS / 8) begin
                if ($urandom_range(9) == 0)
                    send_cmd(16'($urandom_range(1) ? 16'h7FFF : 16'h8000),
                             16'($urandom), rand_fs(), 0, none);
                else
                    send_cmd(16'($urandom), 16'($urandom), rand_fs(), 0, none);
                if ($urandom_range(299) == 0) begin
                    // pause until every expected result is back
                    i_valid <= 1'b0;
                    while (duty_q.size() != 0) @(posedge i_clk);
                end
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        $display("Run covered %0d command beats, %0d result beats, across 12 settings",
                 beats_in, beats_out);
        $display("with directed extremes, random commands and idling on both sides.");
        if (errors == 0 && duty_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
